// ----- rtl/core/arp_cache_and_responder_top_macros.svh -----
// assertion macros for the arp cache and responder
`ifndef ARP_CACHE_AND_RESPONDER_TOP_MACROS_SVH
`define ARP_CACHE_AND_RESPONDER_TOP_MACROS_SVH

// property that must hold on every clock edge out of reset
`define ARPC_ASSERT_ALWAYS(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// condition in one cycle implies a condition in the next
`define ARPC_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

// ----- rtl/core/arpc_pkg.sv -----
// package with request, response and state types of the arp cache
`default_nettype none
package arpc_pkg;

    localparam int unsigned IP_W  = 32;
    localparam int unsigned MAC_W = 48;
    localparam int unsigned OP_W  = 16;
    localparam int unsigned LEN_W = 16;

    localparam logic MODE_LOOKUP = 1'b0;
    localparam logic MODE_PACKET = 1'b1;

    localparam logic [OP_W-1:0] OPCODE_REQUEST = 16'd1;

    typedef struct packed {
        logic             mode;
        logic [IP_W-1:0]  ip;
        logic [MAC_W-1:0] mac;
        logic [OP_W-1:0]  opcode;
        logic [IP_W-1:0]  tgt_ip;
        logic [LEN_W-1:0] frame_length;
    } t_arp_req;

    typedef struct packed {
        logic             hit;
        logic [MAC_W-1:0] found_mac;
        logic             accepted;
        logic             send_reply;
        logic [MAC_W-1:0] reply_mac;
        logic [IP_W-1:0]  reply_ip;
    } t_arp_rsp;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_FINISH
    } t_state;

endpackage
`default_nettype wire

// ----- rtl/core/arp_cache_and_responder_top.sv -----
// arp cache and responder: table scan sequencer, shared compare unit and entry ram
//
// channel   direction  handshake               payload
// request   in         start high, busy low    i_req  (arpc_pkg::t_arp_req)
// response  out        o_rsp_vld for one cycle o_rsp  (arpc_pkg::t_arp_rsp)
// config    in         i_cfg_we                i_cfg_data (local ip)
//
// while busy the sequencer reads one table entry per cycle through the ram read port
// (state scan), checks each registered row in the single ip comparator, then in state
// finish compares the target ip and, for a long packet frame, writes the entry back
// the response strobe rises as busy falls; a new request may be accepted in the strobe
// cycle itself, so each request is taken only after the previous one is complete
// synchronous reset clears all entry valid bits, the local ip and the sequencer
// the receiver cannot stall the response
`default_nettype none
`include "arp_cache_and_responder_top_macros.svh"
module arp_cache_and_responder_top #(
    parameter int unsigned ENTRIES         = 16,
    parameter int unsigned MIN_FRAME_BYTES = 42
) (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              start,
    output logic                   busy,
    input  wire arpc_pkg::t_arp_req i_req,
    output logic                   o_rsp_vld,
    output arpc_pkg::t_arp_rsp     o_rsp,
    input  wire logic              i_cfg_we,
    input  wire logic [31:0]       i_cfg_data
);

    localparam int unsigned IW     = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
    localparam int unsigned CW     = $clog2(ENTRIES + 1);
    localparam int unsigned ROW_W  = arpc_pkg::IP_W + arpc_pkg::MAC_W;
    localparam logic [IW-1:0] LAST_IDX = IW'(ENTRIES - 1);
    localparam logic [CW-1:0] CNT_END  = CW'(ENTRIES);
    localparam logic [arpc_pkg::LEN_W-1:0] MIN_LEN = arpc_pkg::LEN_W'(MIN_FRAME_BYTES);

    arpc_pkg::t_state   r_state, n_state;
    arpc_pkg::t_arp_req r_req, n_req;
    arpc_pkg::t_arp_rsp r_rsp, n_rsp;
    logic               r_rsp_vld, n_rsp_vld;
    logic [31:0]        r_local_ip, n_local_ip;
    logic [ENTRIES-1:0] r_valid, n_valid;

    logic [CW-1:0]      r_rd_cnt, n_rd_cnt;
    logic               r_cmp_vld, n_cmp_vld;
    logic [IW-1:0]      r_cmp_idx, n_cmp_idx;
    logic               r_hit, n_hit;
    logic [IW-1:0]      r_hit_idx, n_hit_idx;
    logic [arpc_pkg::MAC_W-1:0] r_hit_mac, n_hit_mac;
    logic               r_free, n_free;
    logic [IW-1:0]      r_free_idx, n_free_idx;

    logic               ram_we, ram_re;
    logic [IW-1:0]      ram_waddr, ram_raddr;
    logic [ROW_W-1:0]   ram_wdata, ram_rdata;
    logic [arpc_pkg::IP_W-1:0]  row_ip;
    logic [arpc_pkg::MAC_W-1:0] row_mac;

    logic [arpc_pkg::IP_W-1:0] cmp_a, cmp_b;
    logic               cmp_eq;
    logic               long_frame;
    logic               do_reply;
    logic [IW-1:0]      wr_idx;

    arpc_ram #(
        .WIDTH (ROW_W),
        .DEPTH (ENTRIES),
        .AW    (IW)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_re    (ram_re),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    assign row_ip  = ram_rdata[ROW_W-1 -: arpc_pkg::IP_W];
    assign row_mac = ram_rdata[arpc_pkg::MAC_W-1:0];

    // shared ip comparator
    always_comb begin
        if (r_state == arpc_pkg::ST_FINISH) begin
            cmp_a = r_req.tgt_ip;
            cmp_b = r_local_ip;
        end else begin
            cmp_a = row_ip;
            cmp_b = r_req.ip;
        end
    end
    assign cmp_eq = (cmp_a == cmp_b);

    assign long_frame = !(r_req.frame_length < MIN_LEN);
    assign do_reply   = long_frame && (r_req.opcode == arpc_pkg::OPCODE_REQUEST) && cmp_eq;
    assign wr_idx     = r_hit ? r_hit_idx : (r_free ? r_free_idx : '0);

    always_comb begin
        n_state    = r_state;
        n_req      = r_req;
        n_rsp      = r_rsp;
        n_rsp_vld  = 1'b0;
        n_local_ip = r_local_ip;
        n_valid    = r_valid;
        n_rd_cnt   = r_rd_cnt;
        n_cmp_vld  = 1'b0;
        n_cmp_idx  = r_cmp_idx;
        n_hit      = r_hit;
        n_hit_idx  = r_hit_idx;
        n_hit_mac  = r_hit_mac;
        n_free     = r_free;
        n_free_idx = r_free_idx;
        ram_we     = 1'b0;
        ram_waddr  = wr_idx;
        ram_wdata  = {r_req.ip, r_req.mac};
        ram_re     = 1'b0;
        ram_raddr  = r_rd_cnt[IW-1:0];

        if (i_cfg_we) begin
            n_local_ip = i_cfg_data;
        end

        case (r_state)
            arpc_pkg::ST_IDLE: begin
                if (start) begin
                    n_req    = i_req;
                    n_rd_cnt = '0;
                    n_hit    = 1'b0;
                    n_free   = 1'b0;
                    n_state  = arpc_pkg::ST_SCAN;
                end
            end
            arpc_pkg::ST_SCAN: begin
                if (r_rd_cnt < CNT_END) begin
                    ram_re    = 1'b1;
                    n_rd_cnt  = r_rd_cnt + 1'b1;
                    n_cmp_vld = 1'b1;
                    n_cmp_idx = r_rd_cnt[IW-1:0];
                end
                if (r_cmp_vld) begin
                    if (r_valid[r_cmp_idx] && cmp_eq && !r_hit) begin
                        n_hit     = 1'b1;
                        n_hit_idx = r_cmp_idx;
                        n_hit_mac = row_mac;
                    end
                    if (!r_valid[r_cmp_idx] && !r_free) begin
                        n_free     = 1'b1;
                        n_free_idx = r_cmp_idx;
                    end
                    if (r_cmp_idx == LAST_IDX) begin
                        n_state = arpc_pkg::ST_FINISH;
                    end
                end
            end
            arpc_pkg::ST_FINISH: begin
                n_rsp     = '0;
                n_rsp_vld = 1'b1;
                n_state   = arpc_pkg::ST_IDLE;
                if (r_req.mode == arpc_pkg::MODE_LOOKUP) begin
                    n_rsp.hit       = r_hit;
                    n_rsp.found_mac = r_hit ? r_hit_mac : '0;
                end else if (long_frame) begin
                    ram_we          = 1'b1;
                    n_valid[wr_idx] = 1'b1;
                    n_rsp.accepted  = 1'b1;
                    if (do_reply) begin
                        n_rsp.send_reply = 1'b1;
                        n_rsp.reply_mac  = r_req.mac;
                        n_rsp.reply_ip   = r_req.ip;
                    end
                end
            end
            default: begin
                n_state = arpc_pkg::ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= arpc_pkg::ST_IDLE;
            r_rsp_vld  <= 1'b0;
            r_local_ip <= '0;
            r_valid    <= '0;
            r_cmp_vld  <= 1'b0;
            r_hit      <= 1'b0;
            r_free     <= 1'b0;
            r_rd_cnt   <= '0;
        end else begin
            r_state    <= n_state;
            r_rsp_vld  <= n_rsp_vld;
            r_local_ip <= n_local_ip;
            r_valid    <= n_valid;
            r_cmp_vld  <= n_cmp_vld;
            r_hit      <= n_hit;
            r_free     <= n_free;
            r_rd_cnt   <= n_rd_cnt;
        end
        r_req      <= n_req;
        r_rsp      <= n_rsp;
        r_cmp_idx  <= n_cmp_idx;
        r_hit_idx  <= n_hit_idx;
        r_hit_mac  <= n_hit_mac;
        r_free_idx <= n_free_idx;
    end

    assign busy      = (r_state != arpc_pkg::ST_IDLE);
    assign o_rsp_vld = r_rsp_vld;
    assign o_rsp     = r_rsp;

    `ARPC_ASSERT_NEXT(a_accept_busy, i_clk, i_rst_n, start && !busy, busy, "accepted request did not raise busy")
    `ARPC_ASSERT_NEXT(a_rsp_single, i_clk, i_rst_n, o_rsp_vld, !o_rsp_vld, "response strobe longer than one cycle")
    `ARPC_ASSERT_ALWAYS(a_hit_vs_learn, i_clk, i_rst_n, !(o_rsp_vld && o_rsp.hit && o_rsp.accepted), "lookup hit and packet learn in one response")
    `ARPC_ASSERT_ALWAYS(a_reply_needs_learn, i_clk, i_rst_n, !(o_rsp_vld && o_rsp.send_reply && !o_rsp.accepted), "reply requested for a packet that was not learned")

endmodule
`default_nettype wire

// ----- rtl/core/arpc_ram.sv -----
// generic single write port ram with registered read
`default_nettype none
module arpc_ram #(
    parameter int unsigned WIDTH = 80,
    parameter int unsigned DEPTH = 16,
    parameter int unsigned AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic             i_clk,
    input  wire logic             i_we,
    input  wire logic [AW-1:0]    i_waddr,
    input  wire logic [WIDTH-1:0] i_wdata,
    input  wire logic             i_re,
    input  wire logic [AW-1:0]    i_raddr,
    output logic      [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule
`default_nettype wire

// ----- test/arp_cache_checker.sv -----
// checker that predicts and compares the responses of the arp cache and responder
module arp_cache_checker #(
    parameter int unsigned ENTRIES         = 16,
    parameter int unsigned MIN_FRAME_BYTES = 42
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_start,
    input  logic               i_busy,
    input  arpc_pkg::t_arp_req i_req,
    input  logic               i_rsp_vld,
    input  arpc_pkg::t_arp_rsp i_rsp,
    input  logic               i_cfg_we,
    input  logic [31:0]        i_cfg_data,
    input  logic               i_end_of_test,
    output int                 o_pending,
    output int                 o_errors
);
    timeunit 1ns;
    timeprecision 1ps;

    logic                       entry_valid [ENTRIES];
    logic [arpc_pkg::IP_W-1:0]  entry_ip    [ENTRIES];
    logic [arpc_pkg::MAC_W-1:0] entry_mac   [ENTRIES];
    logic [arpc_pkg::IP_W-1:0]  local_ip = '0;
    arpc_pkg::t_arp_rsp         answers_due [$];
    int                         error_count = 0;
    int                         rsp_count = 0;
    bit                         end_seen = 1'b0;

    task automatic log_mismatch(input string msg);
        $display("[%0t] mismatch: %s", $time, msg);
        error_count++;
    endtask

    task automatic check_field(input string name, input logic [63:0] got,
                               input logic [63:0] want);
        if (got !== want) begin
            log_mismatch($sformatf("response %0d field %s got %h want %h",
                                   rsp_count, name, got, want));
        end
    endtask

    function automatic int find_ip(input logic [arpc_pkg::IP_W-1:0] addr);
        for (int i = 0; i < ENTRIES; i++) begin
            if (entry_valid[i] && entry_ip[i] == addr) begin
                return i;
            end
        end
        return -1;
    endfunction

    function automatic arpc_pkg::t_arp_rsp arp_table_step(input arpc_pkg::t_arp_req r);
        arpc_pkg::t_arp_rsp a;
        int slot;
        a = '0;
        slot = find_ip(r.ip);
        if (r.mode == arpc_pkg::MODE_LOOKUP) begin
            if (slot >= 0) begin
                a.hit = 1'b1;
                a.found_mac = entry_mac[slot];
            end
        end else if (r.frame_length >= MIN_FRAME_BYTES) begin
            if (slot < 0) begin
                // lowest free slot, slot 0 when the table is full
                slot = 0;
                for (int i = ENTRIES - 1; i >= 0; i--) begin
                    if (!entry_valid[i]) begin
                        slot = i;
                    end
                end
                entry_valid[slot] = 1'b1;
                entry_ip[slot] = r.ip;
            end
            entry_mac[slot] = r.mac;
            a.accepted = 1'b1;
            if (r.opcode == arpc_pkg::OPCODE_REQUEST && r.tgt_ip == local_ip) begin
                a.send_reply = 1'b1;
                a.reply_mac = r.mac;
                a.reply_ip = r.ip;
            end
        end
        return a;
    endfunction

    always @(posedge i_clk) begin : watch
        arpc_pkg::t_arp_rsp want;
        if (!i_rst_n) begin
            for (int i = 0; i < ENTRIES; i++) begin
                entry_valid[i] = 1'b0;
                entry_ip[i] = '0;
                entry_mac[i] = '0;
            end
            local_ip = '0;
            answers_due.delete();
        end else begin
            if (i_rsp_vld) begin
                if (answers_due.size() == 0) begin
                    log_mismatch($sformatf("response %0d with no request outstanding",
                                           rsp_count));
                end else begin
                    want = answers_due.pop_front();
                    check_field("hit", 64'(i_rsp.hit), 64'(want.hit));
                    check_field("found_mac", 64'(i_rsp.found_mac), 64'(want.found_mac));
                    check_field("accepted", 64'(i_rsp.accepted), 64'(want.accepted));
                    check_field("send_reply", 64'(i_rsp.send_reply), 64'(want.send_reply));
                    check_field("reply_mac", 64'(i_rsp.reply_mac), 64'(want.reply_mac));
                    check_field("reply_ip", 64'(i_rsp.reply_ip), 64'(want.reply_ip));
                end
                rsp_count++;
            end
            if (i_start && !i_busy) begin
                answers_due.push_back(arp_table_step(i_req));
            end
            if (i_cfg_we) begin
                local_ip = i_cfg_data;
            end
            if (i_end_of_test && !end_seen) begin
                end_seen = 1'b1;
                if (answers_due.size() != 0) begin
                    log_mismatch($sformatf("%0d responses never arrived",
                                           answers_due.size()));
                end
            end
        end
        o_pending <= answers_due.size();
        o_errors <= error_count;
    end

endmodule

// ----- test/testbench.sv -----
// top of the arp cache testbench: clock, reset, request stimulus and verdict
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int unsigned ENTRIES         = 16;
    localparam int unsigned MIN_FRAME_BYTES = 42;
    localparam int          PHASES          = 6;
    localparam int          PHASE_ITEMS     = 325;
    localparam int          POOL_MAX        = 24;
    localparam int          POOL_SMALL      = 8;
    localparam logic [arpc_pkg::OP_W-1:0] OPCODE_REPLY = 16'd2;

    logic                      i_clk = 1'b0;
    logic                      i_rst_n = 1'b0;
    logic                      start = 1'b0;
    logic                      busy;
    arpc_pkg::t_arp_req        i_req = '0;
    logic                      o_rsp_vld;
    arpc_pkg::t_arp_rsp        o_rsp;
    logic                      i_cfg_we = 1'b0;
    logic [31:0]               i_cfg_data = '0;
    logic                      end_of_test = 1'b0;
    int                        pending;
    int                        errors;
    logic [arpc_pkg::IP_W-1:0] station_ip = '0;
    logic [arpc_pkg::IP_W-1:0] ip_pool [POOL_MAX];
    int                        pool_size = POOL_SMALL;

    arp_cache_and_responder_top #(
        .ENTRIES         (ENTRIES),
        .MIN_FRAME_BYTES (MIN_FRAME_BYTES)
    ) dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .start      (start),
        .busy       (busy),
        .i_req      (i_req),
        .o_rsp_vld  (o_rsp_vld),
        .o_rsp      (o_rsp),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_data (i_cfg_data)
    );

    arp_cache_checker #(
        .ENTRIES         (ENTRIES),
        .MIN_FRAME_BYTES (MIN_FRAME_BYTES)
    ) checker_i (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_start       (start),
        .i_busy        (busy),
        .i_req         (i_req),
        .i_rsp_vld     (o_rsp_vld),
        .i_rsp         (o_rsp),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_data    (i_cfg_data),
        .i_end_of_test (end_of_test),
        .o_pending     (pending),
        .o_errors      (errors)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    initial begin
        #5ms;
        $display("testbench: errors");
        $finish;
    end

    function automatic arpc_pkg::t_arp_req arp_packet(
        input logic [arpc_pkg::IP_W-1:0]  ip,
        input logic [arpc_pkg::MAC_W-1:0] mac,
        input logic [arpc_pkg::OP_W-1:0]  op,
        input logic [arpc_pkg::IP_W-1:0]  tgt,
        input logic [arpc_pkg::LEN_W-1:0] len);
        arpc_pkg::t_arp_req r;
        r.mode = arpc_pkg::MODE_PACKET;
        r.ip = ip;
        r.mac = mac;
        r.opcode = op;
        r.tgt_ip = tgt;
        r.frame_length = len;
        return r;
    endfunction

    function automatic arpc_pkg::t_arp_req arp_lookup(input logic [arpc_pkg::IP_W-1:0] ip);
        arpc_pkg::t_arp_req r;
        r = '0;
        r.mode = arpc_pkg::MODE_LOOKUP;
        r.ip = ip;
        return r;
    endfunction

    function automatic arpc_pkg::t_arp_req random_req();
        arpc_pkg::t_arp_req r;
        r.mode = $urandom_range(0, 1) ? arpc_pkg::MODE_PACKET : arpc_pkg::MODE_LOOKUP;
        r.ip = ($urandom_range(0, 9) == 0) ? $urandom : ip_pool[$urandom_range(0, pool_size - 1)];
        r.mac = {16'($urandom), 32'($urandom)};
        case ($urandom_range(0, 9)) inside
            [0:4]: r.opcode = arpc_pkg::OPCODE_REQUEST;
            [5:7]: r.opcode = OPCODE_REPLY;
            default: r.opcode = 16'($urandom);
        endcase
        case ($urandom_range(0, 4))
            0: r.tgt_ip = $urandom;
            1: r.tgt_ip = ip_pool[$urandom_range(0, pool_size - 1)];
            default: r.tgt_ip = station_ip;
        endcase
        case ($urandom_range(0, 9))
            0: r.frame_length = 16'($urandom_range(0, MIN_FRAME_BYTES - 1));
            1: r.frame_length = 16'($urandom);
            2: r.frame_length = 16'($urandom_range(MIN_FRAME_BYTES - 1, MIN_FRAME_BYTES));
            default: r.frame_length = 16'($urandom_range(MIN_FRAME_BYTES, 1518));
        endcase
        return r;
    endfunction

    task automatic send_req(input arpc_pkg::t_arp_req r);
        start <= 1'b1;
        i_req <= r;
        do @(posedge i_clk); while (busy);
    endtask

    task automatic settle();
        start <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        repeat (3) @(posedge i_clk);
    endtask

    task automatic set_station_ip(input logic [arpc_pkg::IP_W-1:0] v);
        settle();
        i_cfg_we <= 1'b1;
        i_cfg_data <= v;
        station_ip = v;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    initial begin
        bit idling;
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed requests
        set_station_ip(32'hC0A8_0001);
        send_req(arp_lookup('0));
        send_req(arp_packet('0, '0, arpc_pkg::OPCODE_REQUEST, station_ip, 16'd42));
        send_req(arp_lookup('0));
        send_req(arp_packet('1, '1, OPCODE_REPLY, '1, '1));
        send_req(arp_lookup('1));
        send_req(arp_packet('1, 48'h0123_4567_89AB, arpc_pkg::OPCODE_REQUEST, station_ip,
                            16'd41));
        send_req(arp_lookup('1));
        send_req(arp_packet('1, 48'h0123_4567_89AB, arpc_pkg::OPCODE_REQUEST, station_ip,
                            16'd42));
        send_req(arp_lookup('1));
        send_req(arp_packet(32'h0A00_0002, 48'h0200_0000_0002, arpc_pkg::OPCODE_REQUEST,
                            station_ip ^ 32'd1, 16'd60));
        send_req(arp_packet(32'h0A00_0003, 48'h0200_0000_0003, 16'hFFFF, station_ip, 16'd60));
        send_req(arp_packet(32'h0A00_0004, 48'h0200_0000_0004, 16'h0000, station_ip, 16'd60));
        send_req(arp_packet(32'h0A00_0005, 48'h0200_0000_0005, arpc_pkg::OPCODE_REQUEST,
                            station_ip, '0));
        send_req(arp_lookup(32'h0A00_0005));
        send_req(arp_lookup(32'h0A00_0002));
        send_req('{mode: arpc_pkg::MODE_LOOKUP, ip: '1, mac: '1,
                   opcode: arpc_pkg::OPCODE_REQUEST, tgt_ip: station_ip,
                   frame_length: 16'd100});
        send_req(arp_packet(32'h8000_0001, 48'h8000_0000_0001, arpc_pkg::OPCODE_REQUEST,
                            station_ip, '1));
        send_req(arp_lookup(32'h8000_0001));

        // random phases
        for (int p = 0; p < PHASES; p++) begin
            case (p)
                0: set_station_ip('0);
                1: set_station_ip('1);
                default: set_station_ip($urandom);
            endcase
            pool_size = (p % 2) ? POOL_MAX : POOL_SMALL;
            foreach (ip_pool[i]) ip_pool[i] = $urandom;
            idling = 1'b1;
            for (int n = 0; n < PHASE_ITEMS; n++) begin
                if (n % 40 == 0) begin
                    idling = $urandom_range(0, 1);
                end
                if (p == 2 && n == PHASE_ITEMS / 2) begin
                    settle();
                end
                send_req(random_req());
                if (p != PHASES - 1 && idling && $urandom_range(0, 2) == 0) begin
                    start <= 1'b0;
                    repeat ($urandom_range(1, 10)) @(posedge i_clk);
                end
            end
        end

        start <= 1'b0;
        @(posedge i_clk);
        for (int w = 0; w < 1000 && pending != 0; w++) @(posedge i_clk);
        repeat (25) @(posedge i_clk);
        end_of_test <= 1'b1;
        repeat (2) @(posedge i_clk);
        if (errors == 0) begin
            $display("testbench: clean");
        end else begin
            $display("testbench: errors");
        end
        $finish;
    end

endmodule

// ----- sim.f -----
+incdir+rtl/core
rtl/core/arpc_pkg.sv
rtl/core/arpc_ram.sv
rtl/core/arp_cache_and_responder_top.sv
test/arp_cache_checker.sv
test/testbench.sv
